// ===== design/fsp_pkg.sv =====
// package: shared constants, register indexes and control types of the span rasterizer
`timescale 1ns / 1ps
package fsp_pkg;

	localparam int COORD_W   = 12;
	localparam int COLOR_W   = 32;
	localparam int ROW_W     = 11;
	localparam int OFFSET_W  = 22;
	localparam int COL_W     = 11;
	localparam int DIM_W     = 12;
	localparam int RADIUS_W  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam int DEFAULT_MAX_RADIUS = 31;

	localparam logic [DIM_W-1:0] DIM_LIMIT = 12'd2048;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_ROW_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd4;

	// register reset values
	localparam logic [RADIUS_W-1:0] RST_BRUSH_RADIUS  = 5'd4;
	localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT  = 12'd480;
	localparam logic [ROW_W-1:0]    RST_TOP_ROW_LIMIT = 11'd40;
	localparam logic [DIM_W-1:0]    RST_ROW_STRIDE    = 12'd640;

	typedef struct packed {
		logic [RADIUS_W-1:0] brush_radius;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic [ROW_W-1:0]    top_row_limit;
		logic [DIM_W-1:0]    row_stride;
	} fsp_cfg_t;

	typedef struct packed {
		logic load_dot;
		logic setup;
		logic start_rows;
		logic row_calc;
		logic step;
		logic emit;
	} fsp_cmd_t;

	typedef struct packed {
		logic no_rows;
		logic step_needed;
		logic last_row;
		logic out_free;
	} fsp_sts_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_LIMIT) ? DIM_LIMIT : v;
	endfunction

endpackage

// ===== design/fsp_if.sv =====
// interfaces: dot input channel and span output channel
`timescale 1ns / 1ps
interface fsp_dot_if
	import fsp_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] center_col;
	logic signed [COORD_W-1:0] center_y;
	logic [COLOR_W-1:0]        brush_color;

	modport source (output valid, center_col, center_y, brush_color, input ready);
	modport sink (input valid, center_col, center_y, brush_color, output ready);
endinterface

interface fsp_span_if
	import fsp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ROW_W-1:0]    span_row;
	logic [OFFSET_W-1:0] row_offset;
	logic [COL_W-1:0]    x_first;
	logic [COL_W-1:0]    x_final;
	logic                span_empty;
	logic [COLOR_W-1:0]  pixel_color;
	logic                last_span;

	modport source (output valid, span_row, row_offset, x_first, x_final, span_empty,
		pixel_color, last_span, input ready);
	modport sink (input valid, span_row, row_offset, x_first, x_final, span_empty,
		pixel_color, last_span, output ready);
endinterface

// ===== design/fsp_cfg.sv =====
// configuration register file of the span rasterizer
`timescale 1ns / 1ps
module fsp_cfg
	import fsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output fsp_cfg_t              cfg
);

	fsp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brush_radius  <= RST_BRUSH_RADIUS;
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.image_height  <= RST_IMAGE_HEIGHT;
			cfg_q.top_row_limit <= RST_TOP_ROW_LIMIT;
			cfg_q.row_stride    <= RST_ROW_STRIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRUSH_RADIUS:  cfg_q.brush_radius  <= cfg_data[RADIUS_W-1:0];
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[DIM_W-1:0];
				REG_TOP_ROW_LIMIT: cfg_q.top_row_limit <= cfg_data[ROW_W-1:0];
				REG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/fsp_ctrl.sv =====
// controller state machine: sequences setup, row calc, half-width search and span emit
`timescale 1ns / 1ps
module fsp_ctrl
	import fsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fsp_sts_t sts,
	output fsp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SETUP  = 5'b00010,
		ST_START  = 5'b00100,
		ST_ROW    = 5'b01000,
		ST_SEARCH = 5'b10000
	} fsp_state_t;

	fsp_state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_dot = 1'b1;
					state_d      = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_START;
			end
			ST_START: begin
				if (sts.no_rows) begin
					state_d = ST_IDLE;
				end else begin
					cmd.start_rows = 1'b1;
					state_d        = ST_ROW;
				end
			end
			ST_ROW: begin
				cmd.row_calc = 1'b1;
				state_d      = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sts.step_needed) begin
					cmd.step = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_row ? ST_IDLE : ST_ROW;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/fsp_dp.sv =====
// datapath: row range, row offset, half-width search, column clipping and span register
`timescale 1ns / 1ps
module fsp_dp
	import fsp_pkg::*;
#(
	parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fsp_cfg_t                  cfg,
	input  fsp_cmd_t                  cmd,
	output fsp_sts_t                  sts,
	input  logic signed [COORD_W-1:0] center_col,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic [COLOR_W-1:0]        brush_color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ROW_W-1:0]          span_row,
	output logic [OFFSET_W-1:0]       row_offset,
	output logic [COL_W-1:0]          x_first,
	output logic [COL_W-1:0]          x_final,
	output logic                      span_empty,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic                      last_span
);

	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int LW = 2 * RW;
	localparam int TW = 2 * (RW + 1);
	localparam int SW = 14;
	localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(MAX_RADIUS);

	// dot registers
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [COLOR_W-1:0]        color_q;
	logic [RW-1:0]             r_q;
	logic [DIM_W-1:0]          w_q, h_q, stride_q;
	// row walk registers
	logic signed [SW-1:0]      y0_q, y1_q;
	logic [LW-1:0]             r2_q;
	logic [ROW_W-1:0]          yy_q;
	logic [LW-1:0]             lim_q;
	logic [OFFSET_W-1:0]       offset_q;
	logic [RW-1:0]             dx_q;
	logic                      up_q, first_q;
	// span register
	logic                      out_valid_q;
	logic [ROW_W-1:0]          span_row_q;
	logic [OFFSET_W-1:0]       row_offset_q;
	logic [COL_W-1:0]          x_first_q, x_final_q;
	logic                      span_empty_q, last_span_q;
	logic [COLOR_W-1:0]        pixel_color_q;

	logic signed [SW-1:0] cx_e, cy_e, r_e, top_e, hmax, wmax, dx_e;
	logic signed [SW-1:0] y_lo, y_hi, y0_d, y1_d;
	logic signed [SW-1:0] dy, ady, x0, x1, x0c, x1c;
	logic [RW-1:0]        ady_n;
	logic [LW-1:0]        dysq;
	logic [RW:0]          trial;
	logic [TW-1:0]        trial_sq;
	logic [TW-1:0]        lim_e;
	logic [RADIUS_W-1:0]  r_sat;
	logic                 empty;

	assign r_sat = (cfg.brush_radius > RMAX) ? RMAX : cfg.brush_radius;

	assign cx_e  = SW'(cx_q);
	assign cy_e  = SW'(cy_q);
	assign r_e   = $signed(SW'(r_q));
	assign dx_e  = $signed(SW'(dx_q));
	assign top_e = $signed(SW'(cfg.top_row_limit));
	assign hmax  = $signed(SW'(h_q)) - SW'(1);
	assign wmax  = $signed(SW'(w_q)) - SW'(1);

	// clipped row range
	assign y_lo = cy_e - r_e;
	assign y_hi = cy_e + r_e;
	assign y0_d = (y_lo < top_e) ? top_e : y_lo;
	assign y1_d = (y_hi > hmax) ? hmax : y_hi;

	// row distance from center, |dy| never exceeds the radius inside the range
	assign dy    = $signed(SW'(yy_q)) - cy_e;
	assign ady   = dy[SW-1] ? -dy : dy;
	assign ady_n = ady[RW-1:0];
	assign dysq  = LW'(ady_n) * LW'(ady_n);

	// half-width search: step up toward the center, down away from it
	assign trial    = up_q ? ({1'b0, dx_q} + (RW+1)'(1)) : {1'b0, dx_q};
	assign trial_sq = TW'(trial) * TW'(trial);
	assign lim_e    = TW'(lim_q);

	// column clip
	assign x0    = cx_e - dx_e;
	assign x1    = cx_e + dx_e;
	assign x0c   = x0[SW-1] ? '0 : x0;
	assign x1c   = (x1 > wmax) ? wmax : x1;
	assign empty = x0c > x1c;

	always_comb begin
		sts.no_rows  = y0_q > y1_q;
		sts.last_row = yy_q == y1_q[ROW_W-1:0];
		sts.out_free = !out_valid_q || out_ready;
		if (up_q) begin
			sts.step_needed = (dx_q < r_q) && (trial_sq <= lim_e);
		end else begin
			sts.step_needed = (dx_q != '0) && (trial_sq > lim_e);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dot) begin
			cx_q     <= center_col;
			cy_q     <= center_y;
			color_q  <= brush_color;
			r_q      <= r_sat[RW-1:0];
			w_q      <= sat_dim(cfg.image_width);
			h_q      <= sat_dim(cfg.image_height);
			stride_q <= sat_dim(cfg.row_stride);
		end
		if (cmd.setup) begin
			y0_q <= y0_d;
			y1_q <= y1_d;
			r2_q <= LW'(r_q) * LW'(r_q);
		end
		if (cmd.start_rows) begin
			yy_q    <= y0_q[ROW_W-1:0];
			dx_q    <= r_q;
			first_q <= 1'b1;
		end
		if (cmd.row_calc) begin
			lim_q    <= r2_q - dysq;
			offset_q <= OFFSET_W'(yy_q) * OFFSET_W'(stride_q);
			up_q     <= !first_q && (dy[SW-1] || (dy == '0));
		end
		if (cmd.step) begin
			if (up_q) begin
				dx_q <= dx_q + RW'(1);
			end else begin
				dx_q <= dx_q - RW'(1);
			end
		end
		if (cmd.emit) begin
			yy_q          <= yy_q + ROW_W'(1);
			first_q       <= 1'b0;
			span_row_q    <= yy_q;
			row_offset_q  <= offset_q;
			x_first_q     <= empty ? '0 : x0c[COL_W-1:0];
			x_final_q     <= empty ? '0 : x1c[COL_W-1:0];
			span_empty_q  <= empty;
			pixel_color_q <= color_q;
			last_span_q   <= sts.last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign span_row    = span_row_q;
	assign row_offset  = row_offset_q;
	assign x_first     = x_first_q;
	assign x_final     = x_final_q;
	assign span_empty  = span_empty_q;
	assign pixel_color = pixel_color_q;
	assign last_span   = last_span_q;

endmodule

// ===== design/filled_circle_span_rasterizer.sv =====
// top level: filled circle span rasterizer, one dot in, one span per painted row out
// after a dot is taken the controller runs setup, start and row calc, then the half-width
//   search, and registers the first span once the span register is free
// each dot passes setup and start, each row a row calc plus its half-width search steps and
//   output stalls, the search using the single shared compare unit (at most r steps on the
//   first row, 3r overall); a new dot is taken only once the last span of the previous one
//   is registered; a dot with no rows inside the clip window gives no spans
// reset: arst_n clears the controller and the span valid, config returns to its reset values
`timescale 1ns / 1ps
module filled_circle_span_rasterizer
	import fsp_pkg::*;
#(
	parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fsp_dot_if.sink               dot,
	fsp_span_if.source            span
);

	fsp_cfg_t cfg;
	fsp_cmd_t cmd;
	fsp_sts_t sts;

	// config registers; the user must write them only while idle, the block does not enforce it
	fsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// controller: takes a dot only when idle, a waiting span does not block intake
	fsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dot.valid),
		.in_ready (dot.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath with the span output register acting as the stage between the two sides
	fsp_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.center_col  (dot.center_col),
		.center_y    (dot.center_y),
		.brush_color (dot.brush_color),
		.out_valid   (span.valid),
		.out_ready   (span.ready),
		.span_row    (span.span_row),
		.row_offset  (span.row_offset),
		.x_first     (span.x_first),
		.x_final     (span.x_final),
		.span_empty  (span.span_empty),
		.pixel_color (span.pixel_color),
		.last_span   (span.last_span)
	);

endmodule

// ===== sim/tb.sv =====
// testbench: self-checking regression of the filled circle span rasterizer
`timescale 1ns / 1ps
module tb;
	import fsp_pkg::*;

	// timing and run shape
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 24;      // a no-row dot only passes setup and start, leave plenty
	localparam int SETTLE_LIMIT   = 40000;   // cycles to wait for outstanding spans
	localparam int RANDOM_PHASES  = 12;
	localparam int DOTS_PER_PHASE = 32;      // dots that paint at least one row
	localparam int MAX_R          = DEFAULT_MAX_RADIUS;

	// register indexes past the end of the map, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

	// idle patterns, sender and receiver idle percentages
	localparam int MODE_SLOW_SINK   = 0;
	localparam int MODE_SLOW_SOURCE = 1;
	localparam int MODE_NO_IDLE     = 2;

	typedef struct {
		logic signed [COORD_W-1:0] center_col;
		logic signed [COORD_W-1:0] center_y;
		logic [COLOR_W-1:0]        brush_color;
	} dot_t;

	typedef struct {
		logic [ROW_W-1:0]    span_row;
		logic [OFFSET_W-1:0] row_offset;
		logic [COL_W-1:0]    x_first;
		logic [COL_W-1:0]    x_final;
		logic                span_empty;
		logic [COLOR_W-1:0]  pixel_color;
		logic                last_span;
	} span_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fsp_dot_if  dot_ch ();
	fsp_span_if span_ch ();

	filled_circle_span_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dot       (dot_ch),
		.span      (span_ch)
	);

	// shadow of the register file as the block should hold it
	fsp_cfg_t shadow_cfg;

	// spans still owed by the block, oldest first
	span_t expected_spans[$];

	int send_idle_pct;
	int recv_idle_pct;

	int mismatches;
	int dots_sent;
	int dots_painted;
	int spans_checked;
	int empty_spans;
	int reg_writes;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#40_000_000;
		$display("filled_circle_span_rasterizer regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("span %0d %s got 0x%0h, expected 0x%0h",
				spans_checked, name, got, want));
	endtask

	function automatic int sat_to_limit(input int v);
		return (v > int'(DIM_LIMIT)) ? int'(DIM_LIMIT) : v;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	// expected spans of one dot under the current shadow registers
	// rows top to bottom, half-width is the largest dx with dx*dx within r*r - dy*dy
	function automatic int predict_spans(input dot_t d);
		int r, w, h, strd, cx, cy;
		int y_top, y_bot, yy, dy, room, dx, x_lo, x_hi, n;
		span_t s;
		r    = (shadow_cfg.brush_radius > MAX_R) ? MAX_R : int'(shadow_cfg.brush_radius);
		w    = sat_to_limit(int'(shadow_cfg.image_width));
		h    = sat_to_limit(int'(shadow_cfg.image_height));
		strd = sat_to_limit(int'(shadow_cfg.row_stride));
		cx   = int'(d.center_col);
		cy   = int'(d.center_y);
		n    = 0;
		// clip the row range to the top limit and the image height
		y_top = cy - r;
		if (y_top < int'(shadow_cfg.top_row_limit))
			y_top = int'(shadow_cfg.top_row_limit);
		y_bot = cy + r;
		if (y_bot >= h)
			y_bot = h - 1;
		for (yy = y_top; yy <= y_bot; yy++) begin
			dy   = yy - cy;
			room = r * r - dy * dy;
			dx   = r;
			while (dx > 0 && dx * dx > room)
				dx--;
			x_lo = (cx - dx < 0) ? 0 : cx - dx;
			x_hi = (cx + dx >= w) ? w - 1 : cx + dx;
			s.span_empty  = (x_lo > x_hi);
			s.span_row    = yy[ROW_W-1:0];
			s.row_offset  = OFFSET_W'(yy * strd);
			s.x_first     = s.span_empty ? '0 : x_lo[COL_W-1:0];
			s.x_final     = s.span_empty ? '0 : x_hi[COL_W-1:0];
			s.pixel_color = d.brush_color;
			s.last_span   = (yy == y_bot);
			expected_spans.push_back(s);
			n++;
		end
		return n;
	endfunction

	task automatic set_idle_mode(input int mode);
		case (mode)
			MODE_SLOW_SINK: begin
				send_idle_pct = 22;
				recv_idle_pct = 66;
			end
			MODE_SLOW_SOURCE: begin
				send_idle_pct = 66;
				recv_idle_pct = 22;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// register write, mirrored into the shadow copy with the register's width
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BRUSH_RADIUS:  shadow_cfg.brush_radius  = value[RADIUS_W-1:0];
			REG_IMAGE_WIDTH:   shadow_cfg.image_width   = value[DIM_W-1:0];
			REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = value[DIM_W-1:0];
			REG_TOP_ROW_LIMIT: shadow_cfg.top_row_limit = value[ROW_W-1:0];
			REG_ROW_STRIDE:    shadow_cfg.row_stride    = value[DIM_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// offer one dot, with random idle cycles first, and predict once it is taken
	// valid is only ever changed at a falling edge and at most once per edge
	task automatic send_dot(input int cx, input int cy, input logic [COLOR_W-1:0] color,
			output int n_spans);
		dot_t d;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			dot_ch.valid <= 1'b0;
			@(negedge clk);
		end
		dot_ch.valid       <= 1'b1;
		dot_ch.center_col  <= cx[COORD_W-1:0];
		dot_ch.center_y    <= cy[COORD_W-1:0];
		dot_ch.brush_color <= color;
		@(posedge clk);
		while (!dot_ch.ready)
			@(posedge clk);
		d.center_col  = cx[COORD_W-1:0];
		d.center_y    = cy[COORD_W-1:0];
		d.brush_color = color;
		n_spans = predict_spans(d);
		dots_sent++;
		if (n_spans > 0)
			dots_painted++;
	endtask

	// drop valid, wait for every owed span, then let a trailing no-row dot finish
	task automatic settle_block();
		int waited;
		@(negedge clk);
		dot_ch.valid <= 1'b0;
		waited = 0;
		while (expected_spans.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_spans.size() != 0) begin
			report_mismatch($sformatf("%0d spans never arrived", expected_spans.size()));
			expected_spans.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: ready changes at the falling edge, random stalls per idle mode
	always @(negedge clk)
		span_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// every accepted span is compared with the oldest expectation
	always @(posedge clk) begin : span_check
		span_t want;
		if (arst_n && span_ch.valid && span_ch.ready) begin
			if (expected_spans.size() == 0) begin
				report_mismatch($sformatf("unexpected span, row 0x%0h", span_ch.span_row));
			end else begin
				want = expected_spans.pop_front();
				check_field("span_row", 32'(span_ch.span_row), 32'(want.span_row));
				check_field("row_offset", 32'(span_ch.row_offset), 32'(want.row_offset));
				check_field("x_first", 32'(span_ch.x_first), 32'(want.x_first));
				check_field("x_final", 32'(span_ch.x_final), 32'(want.x_final));
				check_field("span_empty", 32'(span_ch.span_empty), 32'(want.span_empty));
				check_field("pixel_color", span_ch.pixel_color, want.pixel_color);
				check_field("last_span", 32'(span_ch.last_span), 32'(want.last_span));
				if (want.span_empty)
					empty_spans++;
			end
			spans_checked++;
		end
	end

	// reset window: interior dot, top and left clip, bottom and right clip,
	// partly empty rows at either side, and a dot wholly above the top limit
	task automatic test_reset_window();
		int n;
		send_dot(320, 240, 32'h1234_5678, n);
		send_dot(0, 40, 32'hFFFF_FFFF, n);
		send_dot(639, 479, 32'h0000_0000, n);
		send_dot(-3, 100, 32'hA5A5_A5A5, n);
		send_dot(643, 100, 32'h5A5A_5A5A, n);
		send_dot(100, 30, 32'hDEAD_BEEF, n);
	endtask

	// coordinate extremes: corners of the signed range, rows with every span empty
	task automatic test_coordinate_extremes();
		int n;
		send_dot(-2048, -2048, 32'h0000_0000, n);
		send_dot(2047, 2047, 32'hFFFF_FFFF, n);
		send_dot(-2048, 200, 32'h8000_0001, n);
		send_dot(2047, 200, 32'h7FFF_FFFE, n);
	endtask

	// register corners: zero radius, saturation of width, height and stride, zero width,
	// zero height, zero stride, top limit at its maximum, writes past the map, one-pixel image
	task automatic test_register_corners();
		int n;
		settle_block();
		write_reg(REG_BRUSH_RADIUS, 0);
		send_dot(10, 50, 32'h00FF_00FF, n);

		settle_block();
		write_reg(REG_BRUSH_RADIUS, 4095);
		write_reg(REG_IMAGE_WIDTH, 4095);
		write_reg(REG_IMAGE_HEIGHT, 4095);
		write_reg(REG_TOP_ROW_LIMIT, 0);
		write_reg(REG_ROW_STRIDE, 4095);
		send_dot(1024, 2040, 32'hC3C3_C3C3, n);
		send_dot(2040, 10, 32'h3C3C_3C3C, n);

		settle_block();
		write_reg(REG_IMAGE_WIDTH, 0);
		send_dot(5, 100, 32'h1111_1111, n);

		settle_block();
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_dot(5, 5, 32'h2222_2222, n);

		settle_block();
		write_reg(REG_IMAGE_WIDTH, 2048);
		write_reg(REG_IMAGE_HEIGHT, 2048);
		write_reg(REG_ROW_STRIDE, 0);
		send_dot(300, 300, 32'h3333_3333, n);

		settle_block();
		write_reg(REG_TOP_ROW_LIMIT, 2047);
		write_reg(REG_ROW_STRIDE, 2048);
		send_dot(100, 2047, 32'h4444_4444, n);
		send_dot(2047, 2047, 32'h5555_5555, n);

		// nothing past the map may change the window
		settle_block();
		write_reg(REG_SPARE_A, 4095);
		write_reg(REG_SPARE_B, 0);
		write_reg(REG_SPARE_C, 4095);
		send_dot(700, 2040, 32'h6666_6666, n);

		// one-pixel image
		settle_block();
		write_reg(REG_BRUSH_RADIUS, 1);
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 1);
		write_reg(REG_TOP_ROW_LIMIT, 0);
		write_reg(REG_ROW_STRIDE, 1);
		send_dot(0, 0, 32'h7777_7777, n);
	endtask

	// new random window; height stays nonzero and the top limit inside it,
	// so a dot placed near the image always paints rows
	task automatic randomize_window();
		int rad, wid, hgt, top, strd;
		case ($urandom_range(0, 3))
			0:       rad = MAX_R;
			1:       rad = $urandom_range(0, 31);
			default: rad = $urandom_range(0, 12);
		endcase
		case ($urandom_range(0, 9))
			0:          wid = 0;
			1:          wid = $urandom_range(2049, 4095);
			2, 3, 4:    wid = $urandom_range(1, 64);
			default:    wid = $urandom_range(1, 2048);
		endcase
		case ($urandom_range(0, 9))
			0:          hgt = $urandom_range(2049, 4095);
			1, 2, 3, 4: hgt = $urandom_range(1, 64);
			default:    hgt = $urandom_range(1, 2048);
		endcase
		top = $urandom_range(0, sat_to_limit(hgt) - 1);
		case ($urandom_range(0, 9))
			0:       strd = 0;
			1:       strd = $urandom_range(2049, 4095);
			default: strd = $urandom_range(1, 2048);
		endcase
		write_reg(REG_BRUSH_RADIUS, rad);
		write_reg(REG_IMAGE_WIDTH, wid);
		write_reg(REG_IMAGE_HEIGHT, hgt);
		write_reg(REG_TOP_ROW_LIMIT, top);
		write_reg(REG_ROW_STRIDE, strd);
	endtask

	// random dots over a series of windows and idle patterns
	// mostly centers around the visible window, a tenth anywhere in the signed range
	task automatic test_random_dots();
		int phase, painted, r, w, h, top, cx, cy, n;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_idle_mode(phase * 3 / RANDOM_PHASES);
			settle_block();
			randomize_window();
			r   = int'(shadow_cfg.brush_radius);
			w   = sat_to_limit(int'(shadow_cfg.image_width));
			h   = sat_to_limit(int'(shadow_cfg.image_height));
			top = int'(shadow_cfg.top_row_limit);
			painted = 0;
			while (painted < DOTS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					cx = int'($urandom_range(0, 4095)) - 2048;
					cy = int'($urandom_range(0, 4095)) - 2048;
				end else begin
					cx = clamp_coord(-r - 2 + int'($urandom_range(0, w + 2 * r + 3)));
					cy = clamp_coord(top - r + int'($urandom_range(0, h - 1 - top + 2 * r)));
				end
				send_dot(cx, cy, $urandom(), n);
				if (n > 0)
					painted++;
			end
		end
	endtask

	initial begin
		// known values on the reset, config and dot inputs from time zero
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_BRUSH_RADIUS;
		cfg_data            = '0;
		dot_ch.valid        = 1'b0;
		dot_ch.center_col   = '0;
		dot_ch.center_y     = '0;
		dot_ch.brush_color  = '0;
		mismatches          = 0;
		dots_sent           = 0;
		dots_painted        = 0;
		spans_checked       = 0;
		empty_spans         = 0;
		reg_writes          = 0;
		shadow_cfg.brush_radius  = RST_BRUSH_RADIUS;
		shadow_cfg.image_width   = RST_IMAGE_WIDTH;
		shadow_cfg.image_height  = RST_IMAGE_HEIGHT;
		shadow_cfg.top_row_limit = RST_TOP_ROW_LIMIT;
		shadow_cfg.row_stride    = RST_ROW_STRIDE;
		set_idle_mode(MODE_SLOW_SINK);

		// single reset at the start, released on a falling edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_window();
		test_coordinate_extremes();
		test_register_corners();
		test_random_dots();

		// drain with all stalls off and wait out the tail
		set_idle_mode(MODE_NO_IDLE);
		settle_block();

		$display("covered %0d dots (%0d painting rows), %0d spans checked, %0d empty",
			dots_sent, dots_painted, spans_checked, empty_spans);
		$display("%0d register writes across %0d random windows, %0d mismatches",
			reg_writes, RANDOM_PHASES, mismatches);
		if (mismatches == 0) begin
			$display("filled_circle_span_rasterizer regression: pass");
		end else begin
			$display("filled_circle_span_rasterizer regression: fail");
		end
		$finish;
	end

endmodule
